/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked by clk and reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define C2G_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define C2G_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/c2g_pkg.sv */
// ----------------------------------------------------------------------------
// c2g_pkg
// Types, constants and the arctangent table of the Cartesian to geodetic core.
// ----------------------------------------------------------------------------
package c2g_pkg;

    localparam int MAX_ITERATIONS = 16;
    localparam int CORDIC_STAGES  = 32;
    localparam int TABLE_LEN      = 48;
    localparam int TAB_IDX_W      = 6;
    localparam int STAGE_W        = $clog2(CORDIC_STAGES);
    localparam int ITER_W         = $clog2(MAX_ITERATIONS);
    localparam int DW             = 64;
    localparam int ANG_W          = 34;
    localparam int CFG_W          = 37;
    localparam int CFG_IDX_W      = 2;

    localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;
    localparam logic signed [31:0] INV_K_Q30 = 32'sd652032874;
    localparam logic signed [31:0] QUARTER   = 32'sd1073741824;
    localparam logic [36:0]        FLAT_MAX  = 37'h1000000000;

    localparam logic [32:0] SEMI_RESET  = 33'd6378137000;
    localparam logic [36:0] FLAT_RESET  = 37'd3686454312;
    localparam logic [15:0] LIMIT_RESET = 16'd1;

    localparam logic signed [63:0] H_MAX = 64'sd34359738367;
    localparam logic signed [63:0] H_MIN = -64'sd34359738368;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEMI  = 2'd0,
        CFG_FLAT  = 2'd1,
        CFG_LIMIT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [35:0] pos_x;
        logic signed [35:0] pos_y;
        logic signed [35:0] pos_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] lat_angle;
        logic signed [31:0] lon_angle;
        logic signed [35:0] height_mm;
        logic               converged;
    } result_t;

    typedef enum logic [4:0] {
        OP_E2, OP_AE2, OP_POLAR, OP_LON, OP_P, OP_B1, OP_SC, OP_RY, OP_CW, OP_W,
        OP_PW, OP_ZW, OP_AS, OP_B, OP_CHK, OP_PC, OP_ZS, OP_AW, OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_E2, S_AE2, S_POLAR, S_LON, S_P, S_B1, S_SC, S_RY, S_CW, S_W,
        S_PW, S_ZW, S_AS, S_B, S_CHK, S_PC, S_ZS, S_AW, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        MP_IDLE, MP_LO, MP_HI, MP_SUM
    } mul_ph_t;

    typedef enum logic {
        CM_VEC, CM_ROT
    } cmode_t;

    typedef struct packed {
        logic load;
        logic go;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic polar;
        logic hit;
    } stat_t;

    function automatic logic [31:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                6'd0:    v = 32'd536870912;
                6'd1:    v = 32'd316933406;
                6'd2:    v = 32'd167458907;
                6'd3:    v = 32'd85004756;
                6'd4:    v = 32'd42667331;
                6'd5:    v = 32'd21354465;
                6'd6:    v = 32'd10679838;
                6'd7:    v = 32'd5340245;
                6'd8:    v = 32'd2670163;
                6'd9:    v = 32'd1335087;
                6'd10:   v = 32'd667544;
                6'd11:   v = 32'd333772;
                6'd12:   v = 32'd166886;
                6'd13:   v = 32'd83443;
                6'd14:   v = 32'd41722;
                6'd15:   v = 32'd20861;
                6'd16:   v = 32'd10430;
                6'd17:   v = 32'd5215;
                6'd18:   v = 32'd2608;
                6'd19:   v = 32'd1304;
                6'd20:   v = 32'd652;
                6'd21:   v = 32'd326;
                6'd22:   v = 32'd163;
                6'd23:   v = 32'd81;
                6'd24:   v = 32'd41;
                6'd25:   v = 32'd20;
                6'd26:   v = 32'd10;
                6'd27:   v = 32'd5;
                6'd28:   v = 32'd3;
                6'd29:   v = 32'd1;
                6'd30:   v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

/* hw/rtl/cartesian_to_geodetic_core.sv */
// Each point runs n = 1 to 16 latitude passes; a point on the polar axis runs none.
// One point at a time: busy drops right after done, so the next point is taken only
// after the result. The run time comes from the shared CORDIC unit (three uses per
// pass) and the shared multiplier. done pulses for one cycle with the result, which
// holds until the next result. rst_n clears control and restores register defaults.
// ----------------------------------------------------------------------------
// cartesian_to_geodetic_core
// Earth-centred Cartesian point to geodetic latitude, longitude and height.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cartesian_to_geodetic_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  c2g_pkg::point_t               point,
    output logic                          done,
    output c2g_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [c2g_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [c2g_pkg::CFG_W-1:0]     cfg_data
);

    c2g_pkg::cmd_t  cmd;
    c2g_pkg::stat_t stat;

    c2g_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    c2g_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .point     (point),
        .result    (result),
        .done      (done),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    `C2G_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted point did not raise busy")
    `C2G_ASSERT_NEXT(a_done_idle, done, !busy, "controller not idle after a result")
    `C2G_ASSERT_IMP(a_lat_range, done, result.lat_angle <= c2g_pkg::QUARTER && result.lat_angle >= -c2g_pkg::QUARTER, "latitude outside a quarter turn")

endmodule

/* hw/rtl/c2g_mul.sv */
// ----------------------------------------------------------------------------
// c2g_mul
// Multi-cycle Q30 multiplier: (v * f) / 2^30 with the magnitude truncated,
// built from two partial products of |f| with the low 30 and the high 32 bits of |v|.
// ----------------------------------------------------------------------------
module c2g_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic signed [63:0] v,
    input  logic signed [31:0] f,
    output logic signed [63:0] res,
    output logic               done
);

    c2g_pkg::mul_ph_t ph_reg, ph_next;
    logic             done_reg, done_next;
    logic [61:0]      av_reg;
    logic [31:0]      af_reg;
    logic             neg_reg;
    logic [61:0]      lo_reg;
    logic [63:0]      hi_reg;
    logic signed [63:0] res_reg;

    logic [63:0] av_abs;
    logic [31:0] af_abs;
    logic [63:0] sum;

    always_comb
    begin
        av_abs = v[63] ? 64'(-v) : 64'(v);
        af_abs = f[31] ? 32'(-f) : 32'(f);
        sum    = hi_reg + 64'(lo_reg >> 30);
    end

    always_comb
    begin
        ph_next   = ph_reg;
        done_next = 1'b0;
        case (ph_reg)
            c2g_pkg::MP_IDLE: if (go) ph_next = c2g_pkg::MP_LO;
            c2g_pkg::MP_LO:   ph_next = c2g_pkg::MP_HI;
            c2g_pkg::MP_HI:   ph_next = c2g_pkg::MP_SUM;
            c2g_pkg::MP_SUM:
            begin
                ph_next   = c2g_pkg::MP_IDLE;
                done_next = 1'b1;
            end
            default:          ph_next = c2g_pkg::MP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= c2g_pkg::MP_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ph_reg == c2g_pkg::MP_IDLE && go)
        begin
            av_reg  <= av_abs[61:0];
            af_reg  <= af_abs;
            neg_reg <= v[63] ^ f[31];
        end
        if (ph_reg == c2g_pkg::MP_LO)
            lo_reg <= 62'(av_reg[29:0] * af_reg);
        if (ph_reg == c2g_pkg::MP_HI)
            hi_reg <= av_reg[61:30] * af_reg;
        if (ph_reg == c2g_pkg::MP_SUM)
            res_reg <= neg_reg ? -$signed(sum) : $signed(sum);
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule

/* hw/rtl/c2g_cordic.sv */
// ----------------------------------------------------------------------------
// c2g_cordic
// Circular CORDIC, one stage per clock, in vectoring or rotation mode.
// ----------------------------------------------------------------------------
module c2g_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  c2g_pkg::cmode_t                   mode,
    input  logic signed [63:0]                x0,
    input  logic signed [63:0]                y0,
    input  logic signed [c2g_pkg::ANG_W-1:0]  z0,
    output logic signed [63:0]                x,
    output logic signed [63:0]                y,
    output logic signed [c2g_pkg::ANG_W-1:0]  z,
    output logic                              done
);

    logic signed [63:0]               x_reg, y_reg;
    logic signed [c2g_pkg::ANG_W-1:0] z_reg;
    logic [c2g_pkg::STAGE_W-1:0]      cnt_reg, cnt_next;
    logic                             run_reg, run_next;
    logic                             done_reg, done_next;
    c2g_pkg::cmode_t                  mode_reg;

    logic signed [63:0]               xs, ys;
    logic signed [c2g_pkg::ANG_W-1:0] at;
    logic                             cw;
    logic                             last;

    always_comb
    begin
        xs   = x_reg >>> cnt_reg;
        ys   = y_reg >>> cnt_reg;
        at   = $signed({{(c2g_pkg::ANG_W-32){1'b0}},
                        c2g_pkg::atan_entry(c2g_pkg::TAB_IDX_W'(cnt_reg))});
        // Vectoring drives y toward zero, rotation drives the angle residue.
        cw   = (mode_reg == c2g_pkg::CM_VEC) ? !y_reg[63] : z_reg[c2g_pkg::ANG_W-1];
        last = (cnt_reg == c2g_pkg::STAGE_W'(c2g_pkg::CORDIC_STAGES - 1));
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go && !run_reg)
        begin
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && !run_reg)
        begin
            x_reg    <= x0;
            y_reg    <= y0;
            z_reg    <= z0;
            mode_reg <= mode;
        end
        else if (run_reg)
        begin
            if (cw)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign done = done_reg;

endmodule

/* hw/rtl/c2g_datapath.sv */
// ----------------------------------------------------------------------------
// c2g_datapath
// Configuration registers, working registers, shared CORDIC and multiplier,
// and the result register. Each command starts one operation.
// ----------------------------------------------------------------------------
module c2g_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  c2g_pkg::cmd_t                     cmd,
    output c2g_pkg::stat_t                    stat,
    input  c2g_pkg::point_t                   point,
    output c2g_pkg::result_t                  result,
    output logic                              done,
    input  logic                              cfg_we,
    input  logic [c2g_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [c2g_pkg::CFG_W-1:0]         cfg_data
);

    localparam int AW = c2g_pkg::ANG_W;

    logic [32:0] semi_reg;
    logic [36:0] flat_reg;
    logic [15:0] limit_reg;

    logic signed [63:0] x16_reg, y16_reg, z16_reg, a16_reg, ae2_reg;
    logic signed [63:0] p16_reg, xr_reg, t0_reg, t1_reg;
    logic signed [31:0] onef_reg, e2_reg, w_reg, s_reg, c_reg;
    logic signed [31:0] lon_reg, b1_reg, b_reg;
    logic               conv_reg, polar_reg, hit_reg, imm_done_reg, valid_reg;
    c2g_pkg::result_t   result_reg;

    logic               mul_go, mul_done;
    logic signed [63:0] mul_v, mul_res;
    logic signed [31:0] mul_f;

    logic               cor_go, cor_done;
    c2g_pkg::cmode_t    cor_mode;
    logic signed [63:0] cor_x0, cor_y0, cor_x, cor_y;
    logic signed [AW-1:0] cor_z0, cor_z;

    logic               imm_go;
    logic [36:0]        fl_sat;
    logic signed [31:0] c_abs;
    logic signed [63:0] vx, vy;
    logic signed [AW-1:0] base;
    logic signed [31:0] z_clamp;
    logic signed [32:0] diff, diff_abs;
    logic               hit;
    logic signed [63:0] h_round, h_shift;
    logic signed [35:0] h_sat;

    always_comb
    begin
        fl_sat = (flat_reg > c2g_pkg::FLAT_MAX) ? c2g_pkg::FLAT_MAX : flat_reg;
        c_abs  = c_reg[31] ? -c_reg : c_reg;

        // Fold the left half plane into the right one before vectoring.
        vx   = x16_reg;
        vy   = y16_reg;
        base = '0;
        if (x16_reg[63])
        begin
            if (!y16_reg[63])
            begin
                vx   = y16_reg;
                vy   = -x16_reg;
                base = AW'(c2g_pkg::QUARTER);
            end
            else
            begin
                vx   = -y16_reg;
                vy   = x16_reg;
                base = -AW'(c2g_pkg::QUARTER);
            end
        end

        if (cor_z > AW'(c2g_pkg::QUARTER))
            z_clamp = c2g_pkg::QUARTER;
        else if (cor_z < -AW'(c2g_pkg::QUARTER))
            z_clamp = -c2g_pkg::QUARTER;
        else
            z_clamp = cor_z[31:0];

        diff     = 33'(b_reg) - 33'(b1_reg);
        diff_abs = diff[32] ? -diff : diff;
        hit      = diff_abs < $signed({17'd0, limit_reg});

        h_round = t0_reg + 64'sd32768;
        h_shift = h_round >>> 16;
        if (h_shift > c2g_pkg::H_MAX)
            h_sat = c2g_pkg::H_MAX[35:0];
        else if (h_shift < c2g_pkg::H_MIN)
            h_sat = c2g_pkg::H_MIN[35:0];
        else
            h_sat = h_shift[35:0];
    end

    always_comb
    begin
        mul_go   = 1'b0;
        mul_v    = p16_reg;
        mul_f    = w_reg;
        cor_go   = 1'b0;
        cor_mode = c2g_pkg::CM_VEC;
        cor_x0   = t0_reg;
        cor_y0   = t1_reg;
        cor_z0   = '0;
        imm_go   = 1'b0;
        case (cmd.op)
            c2g_pkg::OP_E2:    begin mul_go = 1'b1; mul_v = 64'(onef_reg);
                                     mul_f = onef_reg; end
            c2g_pkg::OP_AE2:   begin mul_go = 1'b1; mul_v = a16_reg; mul_f = e2_reg; end
            c2g_pkg::OP_P:     begin mul_go = 1'b1; mul_v = xr_reg;
                                     mul_f = c2g_pkg::INV_K_Q30; end
            c2g_pkg::OP_RY:    begin mul_go = 1'b1; mul_v = 64'(s_reg); mul_f = onef_reg; end
            c2g_pkg::OP_W:     begin mul_go = 1'b1; mul_v = xr_reg;
                                     mul_f = c2g_pkg::INV_K_Q30; end
            c2g_pkg::OP_PW:    begin mul_go = 1'b1; mul_v = p16_reg; mul_f = w_reg; end
            c2g_pkg::OP_ZW:    begin mul_go = 1'b1; mul_v = z16_reg; mul_f = w_reg; end
            c2g_pkg::OP_AS:    begin mul_go = 1'b1; mul_v = ae2_reg; mul_f = s_reg; end
            c2g_pkg::OP_PC:    begin mul_go = 1'b1; mul_v = p16_reg; mul_f = c_reg; end
            c2g_pkg::OP_ZS:    begin mul_go = 1'b1; mul_v = z16_reg; mul_f = s_reg; end
            c2g_pkg::OP_AW:    begin mul_go = 1'b1; mul_v = a16_reg; mul_f = w_reg; end
            c2g_pkg::OP_LON:   begin cor_go = 1'b1; cor_x0 = vx; cor_y0 = vy; end
            c2g_pkg::OP_B1:    begin cor_go = 1'b1; cor_x0 = p16_reg; cor_y0 = z16_reg; end
            c2g_pkg::OP_SC:
            begin
                cor_go   = 1'b1;
                cor_mode = c2g_pkg::CM_ROT;
                cor_x0   = 64'(c2g_pkg::INV_K_Q30);
                cor_y0   = '0;
                cor_z0   = AW'(b1_reg);
            end
            c2g_pkg::OP_CW:    begin cor_go = 1'b1; cor_x0 = 64'(c_abs); cor_y0 = t0_reg; end
            c2g_pkg::OP_B:     cor_go = 1'b1;
            c2g_pkg::OP_POLAR: imm_go = 1'b1;
            c2g_pkg::OP_CHK:   imm_go = 1'b1;
            c2g_pkg::OP_OUT:   imm_go = 1'b1;
            default:           imm_go = 1'b1;
        endcase
        mul_go = mul_go & cmd.go;
        cor_go = cor_go & cmd.go;
        imm_go = imm_go & cmd.go;
    end

    c2g_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go),
        .v     (mul_v),
        .f     (mul_f),
        .res   (mul_res),
        .done  (mul_done)
    );

    c2g_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cor_go),
        .mode  (cor_mode),
        .x0    (cor_x0),
        .y0    (cor_y0),
        .z0    (cor_z0),
        .x     (cor_x),
        .y     (cor_y),
        .z     (cor_z),
        .done  (cor_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            semi_reg     <= c2g_pkg::SEMI_RESET;
            flat_reg     <= c2g_pkg::FLAT_RESET;
            limit_reg    <= c2g_pkg::LIMIT_RESET;
            conv_reg     <= 1'b0;
            polar_reg    <= 1'b0;
            hit_reg      <= 1'b0;
            imm_done_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    c2g_pkg::CFG_SEMI:  semi_reg  <= cfg_data[32:0];
                    c2g_pkg::CFG_FLAT:  flat_reg  <= cfg_data[36:0];
                    c2g_pkg::CFG_LIMIT: limit_reg <= cfg_data[15:0];
                    default:            ;
                endcase
            end
            imm_done_reg <= imm_go;
            valid_reg    <= imm_go && (cmd.op == c2g_pkg::OP_OUT);
            if (cmd.load)
            begin
                conv_reg  <= 1'b0;
                polar_reg <= (point.pos_x == '0) && (point.pos_y == '0);
            end
            if (imm_go && cmd.op == c2g_pkg::OP_POLAR)
                conv_reg <= 1'b1;
            if (imm_go && cmd.op == c2g_pkg::OP_CHK)
            begin
                hit_reg <= hit;
                if (hit)
                    conv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x16_reg  <= 64'($signed({point.pos_x, 16'd0}));
            y16_reg  <= 64'($signed({point.pos_y, 16'd0}));
            z16_reg  <= 64'($signed({point.pos_z, 16'd0}));
            a16_reg  <= $signed({15'd0, semi_reg, 16'd0});
            onef_reg <= c2g_pkg::ONE_Q30 - $signed(32'(fl_sat >> 10));
        end
        if (mul_done)
        begin
            case (cmd.op)
                c2g_pkg::OP_E2:  e2_reg  <= c2g_pkg::ONE_Q30 - mul_res[31:0];
                c2g_pkg::OP_AE2: ae2_reg <= mul_res;
                c2g_pkg::OP_P:   p16_reg <= mul_res;
                c2g_pkg::OP_RY:  t0_reg  <= mul_res;
                c2g_pkg::OP_W:   w_reg   <= mul_res[31:0];
                c2g_pkg::OP_PW:  t0_reg  <= mul_res;
                c2g_pkg::OP_ZW:  t1_reg  <= mul_res;
                c2g_pkg::OP_AS:  t1_reg  <= t1_reg + mul_res;
                c2g_pkg::OP_PC:  t0_reg  <= mul_res;
                c2g_pkg::OP_ZS:  t0_reg  <= t0_reg + mul_res;
                c2g_pkg::OP_AW:  t0_reg  <= t0_reg - mul_res;
                default:         ;
            endcase
        end
        if (cor_done)
        begin
            case (cmd.op)
                c2g_pkg::OP_LON:
                begin
                    lon_reg <= 32'(base + cor_z);
                    xr_reg  <= cor_x;
                end
                c2g_pkg::OP_B1:
                    b1_reg <= z_clamp;
                c2g_pkg::OP_SC:
                begin
                    s_reg <= cor_y[31:0];
                    c_reg <= cor_x[31:0];
                end
                c2g_pkg::OP_CW:  xr_reg <= cor_x;
                c2g_pkg::OP_B:   b_reg  <= z_clamp;
                default:         ;
            endcase
        end
        if (imm_go)
        begin
            case (cmd.op)
                c2g_pkg::OP_POLAR:
                begin
                    b1_reg  <= z16_reg[63] ? -c2g_pkg::QUARTER : c2g_pkg::QUARTER;
                    lon_reg <= '0;
                    p16_reg <= '0;
                end
                // The last estimate becomes the latitude whether or not it met the limit.
                c2g_pkg::OP_CHK: b1_reg <= b_reg;
                c2g_pkg::OP_OUT:
                begin
                    result_reg.lat_angle <= b1_reg;
                    result_reg.lon_angle <= lon_reg;
                    result_reg.height_mm <= h_sat;
                    result_reg.converged <= conv_reg;
                end
                default: ;
            endcase
        end
    end

    assign stat.done  = mul_done | cor_done | imm_done_reg;
    assign stat.polar = polar_reg;
    assign stat.hit   = hit_reg;
    assign result     = result_reg;
    assign done       = valid_reg;

endmodule

/* hw/rtl/c2g_ctrl.sv */
// ----------------------------------------------------------------------------
// c2g_ctrl
// Sequencer: issues one datapath operation in each state but idle, waits for its
// completion, and runs the latitude iteration loop.
// ----------------------------------------------------------------------------
module c2g_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output c2g_pkg::cmd_t  cmd,
    input  c2g_pkg::stat_t stat
);

    c2g_pkg::state_t             state_reg, state_next;
    logic                        pend_reg, pend_next;
    logic                        final_reg, final_next;
    logic [c2g_pkg::ITER_W-1:0]  iter_reg, iter_next;
    logic                        in_op;

    always_comb
    begin
        state_next = state_reg;
        final_next = final_reg;
        iter_next  = iter_reg;
        case (state_reg)
            c2g_pkg::S_IDLE:
                if (start)
                begin
                    state_next = c2g_pkg::S_E2;
                    final_next = 1'b0;
                    iter_next  = '0;
                end
            c2g_pkg::S_E2:    if (stat.done) state_next = c2g_pkg::S_AE2;
            c2g_pkg::S_AE2:
                if (stat.done)
                    state_next = stat.polar ? c2g_pkg::S_POLAR : c2g_pkg::S_LON;
            c2g_pkg::S_POLAR:
                if (stat.done)
                begin
                    state_next = c2g_pkg::S_SC;
                    final_next = 1'b1;
                end
            c2g_pkg::S_LON:   if (stat.done) state_next = c2g_pkg::S_P;
            c2g_pkg::S_P:     if (stat.done) state_next = c2g_pkg::S_B1;
            c2g_pkg::S_B1:    if (stat.done) state_next = c2g_pkg::S_SC;
            c2g_pkg::S_SC:    if (stat.done) state_next = c2g_pkg::S_RY;
            c2g_pkg::S_RY:    if (stat.done) state_next = c2g_pkg::S_CW;
            c2g_pkg::S_CW:    if (stat.done) state_next = c2g_pkg::S_W;
            c2g_pkg::S_W:
                if (stat.done)
                    state_next = final_reg ? c2g_pkg::S_PC : c2g_pkg::S_PW;
            c2g_pkg::S_PW:    if (stat.done) state_next = c2g_pkg::S_ZW;
            c2g_pkg::S_ZW:    if (stat.done) state_next = c2g_pkg::S_AS;
            c2g_pkg::S_AS:    if (stat.done) state_next = c2g_pkg::S_B;
            c2g_pkg::S_B:     if (stat.done) state_next = c2g_pkg::S_CHK;
            c2g_pkg::S_CHK:
                if (stat.done)
                begin
                    state_next = c2g_pkg::S_SC;
                    if (stat.hit ||
                        iter_reg == c2g_pkg::ITER_W'(c2g_pkg::MAX_ITERATIONS - 1))
                        final_next = 1'b1;
                    else
                        iter_next = iter_reg + 1'b1;
                end
            c2g_pkg::S_PC:    if (stat.done) state_next = c2g_pkg::S_ZS;
            c2g_pkg::S_ZS:    if (stat.done) state_next = c2g_pkg::S_AW;
            c2g_pkg::S_AW:    if (stat.done) state_next = c2g_pkg::S_OUT;
            c2g_pkg::S_OUT:   if (stat.done) state_next = c2g_pkg::S_IDLE;
            default:          state_next = c2g_pkg::S_IDLE;
        endcase

        pend_next = pend_reg;
        if (in_op)
        begin
            if (stat.done)
                pend_next = 1'b0;
            else if (!pend_reg)
                pend_next = 1'b1;
        end
    end

    always_comb
    begin
        in_op    = 1'b1;
        cmd.op   = c2g_pkg::OP_E2;
        case (state_reg)
            c2g_pkg::S_IDLE:  in_op  = 1'b0;
            c2g_pkg::S_E2:    cmd.op = c2g_pkg::OP_E2;
            c2g_pkg::S_AE2:   cmd.op = c2g_pkg::OP_AE2;
            c2g_pkg::S_POLAR: cmd.op = c2g_pkg::OP_POLAR;
            c2g_pkg::S_LON:   cmd.op = c2g_pkg::OP_LON;
            c2g_pkg::S_P:     cmd.op = c2g_pkg::OP_P;
            c2g_pkg::S_B1:    cmd.op = c2g_pkg::OP_B1;
            c2g_pkg::S_SC:    cmd.op = c2g_pkg::OP_SC;
            c2g_pkg::S_RY:    cmd.op = c2g_pkg::OP_RY;
            c2g_pkg::S_CW:    cmd.op = c2g_pkg::OP_CW;
            c2g_pkg::S_W:     cmd.op = c2g_pkg::OP_W;
            c2g_pkg::S_PW:    cmd.op = c2g_pkg::OP_PW;
            c2g_pkg::S_ZW:    cmd.op = c2g_pkg::OP_ZW;
            c2g_pkg::S_AS:    cmd.op = c2g_pkg::OP_AS;
            c2g_pkg::S_B:     cmd.op = c2g_pkg::OP_B;
            c2g_pkg::S_CHK:   cmd.op = c2g_pkg::OP_CHK;
            c2g_pkg::S_PC:    cmd.op = c2g_pkg::OP_PC;
            c2g_pkg::S_ZS:    cmd.op = c2g_pkg::OP_ZS;
            c2g_pkg::S_AW:    cmd.op = c2g_pkg::OP_AW;
            c2g_pkg::S_OUT:   cmd.op = c2g_pkg::OP_OUT;
            default:          in_op  = 1'b0;
        endcase
        // Each operation is issued once, on the first cycle of its state.
        cmd.go   = in_op && !pend_reg;
        cmd.load = (state_reg == c2g_pkg::S_IDLE) && start;
        busy     = (state_reg != c2g_pkg::S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c2g_pkg::S_IDLE;
            pend_reg  <= 1'b0;
            final_reg <= 1'b0;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            final_reg <= final_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

/* tb/c2g_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c2g_checker
// Watches the point, result and register ports of the Cartesian to geodetic
// core. It predicts the geodetic result of every accepted point and compares
// each returned result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module c2g_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  c2g_pkg::point_t               point,
    input  logic                          done,
    input  c2g_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [c2g_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [c2g_pkg::CFG_W-1:0]     cfg_data,
    output int                            errors,
    output int                            pending
);

    localparam longint QTR   = 64'sd1073741824;
    localparam longint ONE30 = 64'sd1073741824;
    localparam longint INVK  = 64'sd652032874;

    longint arc_tab [0:47] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    logic [32:0]      semi_axis;
    logic [36:0]      flat_frac;
    logic [15:0]      conv_limit;
    c2g_pkg::result_t geo_expected [$];

    assign pending = geo_expected.size();

    // Product of a length and a Q30 fraction, magnitude truncated toward zero.
    function automatic longint frac_mul(longint v, longint f);
        bit                neg;
        longint unsigned   av, af, r;
        neg = (v < 0) != (f < 0);
        av  = (v < 0) ? -v : v;
        af  = (f < 0) ? -f : f;
        r   = (av >> 30) * af + (((av & 64'h3FFFFFFF) * af) >> 30);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp_quarter(longint b);
        if (b > QTR)
            return QTR;
        if (b < -QTR)
            return -QTR;
        return b;
    endfunction

    function automatic longint vec_angle(longint x, longint y, output longint mag);
        longint ang, dx, dy;
        ang = 0;
        for (int i = 0; i < c2g_pkg::CORDIC_STAGES && i < 48; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; ang += arc_tab[i];
            end
            else
            begin
                x -= dx; y += dy; ang -= arc_tab[i];
            end
        end
        mag = frac_mul(x, INVK);
        return ang;
    endfunction

    function automatic void sin_cos(input longint b, output longint s, output longint c);
        longint x, y, z, dx, dy;
        x = INVK; y = 0; z = b;
        for (int i = 0; i < c2g_pkg::CORDIC_STAGES && i < 48; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arc_tab[i];
            end
            else
            begin
                x += dx; y -= dy; z += arc_tab[i];
            end
        end
        s = y;
        c = x;
    endfunction

    function automatic longint radius_factor(longint s, longint c, longint onef);
        longint w, dummy;
        dummy = vec_angle((c < 0) ? -c : c, frac_mul(s, onef), w);
        return w;
    endfunction

    function automatic c2g_pkg::result_t geodetic_of(c2g_pkg::point_t pt);
        c2g_pkg::result_t r;
        longint           x16, y16, z16, a16, onef, e2, lon, lat, p16;
        longint           s, c, w, h16, h, vx, vy, base, b1, b, tmp, d;
        longint unsigned  fl;
        bit               conv;
        x16  = longint'($signed(pt.pos_x)) * 65536;
        y16  = longint'($signed(pt.pos_y)) * 65536;
        z16  = longint'($signed(pt.pos_z)) * 65536;
        a16  = longint'(semi_axis) * 65536;
        fl   = (flat_frac > 37'h1000000000) ? 64'h1000000000 : flat_frac;
        onef = ONE30 - longint'(fl >> 10);
        e2   = ONE30 - frac_mul(onef, onef);
        lon  = 0;
        p16  = 0;
        b    = 0;
        conv = 0;
        if (x16 == 0 && y16 == 0)
        begin
            lat  = (z16 >= 0) ? QTR : -QTR;
            conv = 1;
        end
        else
        begin
            vx = x16; vy = y16; base = 0;
            // Left half plane is rotated by a quarter turn before vectoring.
            if (vx < 0)
            begin
                if (vy >= 0)
                begin
                    vx = y16; vy = -x16; base = QTR;
                end
                else
                begin
                    vx = -y16; vy = x16; base = -QTR;
                end
            end
            lon = base + vec_angle(vx, vy, p16);
            b1  = clamp_quarter(vec_angle(p16, z16, tmp));
            for (int k = 0; k < c2g_pkg::MAX_ITERATIONS; k++)
            begin
                sin_cos(b1, s, c);
                w = radius_factor(s, c, onef);
                b = clamp_quarter(vec_angle(frac_mul(p16, w),
                        frac_mul(z16, w) + frac_mul(frac_mul(a16, e2), s), tmp));
                d = (b < b1) ? b1 - b : b - b1;
                if (d < longint'(conv_limit))
                begin
                    conv = 1;
                    break;
                end
                b1 = b;
            end
            lat = b;
        end
        sin_cos(lat, s, c);
        w   = radius_factor(s, c, onef);
        h16 = frac_mul(p16, c) + frac_mul(z16, s) - frac_mul(a16, w);
        h   = (h16 + 32768) >>> 16;
        if (h > 64'sd34359738367)
            h = 64'sd34359738367;
        if (h < -64'sd34359738368)
            h = -64'sd34359738368;
        r.lat_angle = lat[31:0];
        r.lon_angle = lon[31:0];
        r.height_mm = h[35:0];
        r.converged = conv;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        c2g_pkg::result_t exp_r;
        if (!rst_n)
        begin
            semi_axis  <= c2g_pkg::SEMI_RESET;
            flat_frac  <= c2g_pkg::FLAT_RESET;
            conv_limit <= c2g_pkg::LIMIT_RESET;
            errors     <= 0;
            geo_expected.delete();
        end
        else
        begin
            if (done)
            begin
                if (geo_expected.size() == 0)
                begin
                    $error("result with nothing expected");
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = geo_expected.pop_front();
                    if (result !== exp_r)
                    begin
                        errors <= errors + 1;
                        if (result.lat_angle !== exp_r.lat_angle)
                            $error("lat_angle expected %0d got %0d",
                                   exp_r.lat_angle, result.lat_angle);
                        if (result.lon_angle !== exp_r.lon_angle)
                            $error("lon_angle expected %0d got %0d",
                                   exp_r.lon_angle, result.lon_angle);
                        if (result.height_mm !== exp_r.height_mm)
                            $error("height_mm expected %0d got %0d",
                                   exp_r.height_mm, result.height_mm);
                        if (result.converged !== exp_r.converged)
                            $error("converged expected %0d got %0d",
                                   exp_r.converged, result.converged);
                    end
                end
            end
            // Prediction uses the registers as they stood before this edge.
            if (start && !busy)
                geo_expected.push_back(geodetic_of(point));
            if (cfg_we)
            begin
                case (c2g_pkg::cfg_idx_t'(cfg_index))
                    c2g_pkg::CFG_SEMI:  semi_axis  <= cfg_data[32:0];
                    c2g_pkg::CFG_FLAT:  flat_frac  <= cfg_data;
                    c2g_pkg::CFG_LIMIT: conv_limit <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* tb/cartesian_to_geodetic_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cartesian_to_geodetic_core_tb
// Drives directed and random points through the core under several ellipsoid
// settings, with sender gaps, and lets the checker judge every result.
// ----------------------------------------------------------------------------
module cartesian_to_geodetic_core_tb;

    localparam int IDLE_LIMIT = 50000;

    logic                          clk = 0;
    logic                          rst_n = 0;
    logic                          start = 0;
    logic                          busy;
    c2g_pkg::point_t               point = '0;
    logic                          done;
    c2g_pkg::result_t              result;
    logic                          cfg_we = 0;
    logic [c2g_pkg::CFG_IDX_W-1:0] cfg_index = c2g_pkg::CFG_SEMI;
    logic [c2g_pkg::CFG_W-1:0]     cfg_data = '0;
    int                            errors;
    int                            pending;
    int                            gap_pct = 0;
    int                            quiet_cycles = 0;

    always #5 clk = ~clk;

    cartesian_to_geodetic_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .point(point),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    c2g_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .point(point),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .errors(errors), .pending(pending)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic signed [35:0] rand36();
        return 36'({$urandom(), $urandom()});
    endfunction

    function automatic logic signed [35:0] rand_span(int bits);
        longint v;
        v = longint'({$urandom(), $urandom()}) >>> (64 - bits);
        return v[35:0];
    endfunction

    // Every call starts and ends at a falling edge. busy only changes at a
    // rising edge, so a low busy at a falling edge means the next edge takes
    // the transfer.
    task automatic send_point(input logic signed [35:0] x, y, z);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
        start       <= 1;
        point.pos_x <= x;
        point.pos_y <= y;
        point.pos_z <= z;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input c2g_pkg::cfg_idx_t idx,
                             input logic [c2g_pkg::CFG_W-1:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 0;
    endtask

    task automatic random_points(input int n);
        int kind;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                drain();
            kind = $urandom_range(99);
            // Mostly points near the ellipsoid, some anywhere, some tiny, a few with x zero.
            if (kind < 60)
                send_point(rand_span(34), rand_span(34), rand_span(34));
            else if (kind < 85)
                send_point(rand36(), rand36(), rand36());
            else if (kind < 95)
                send_point(rand_span(20), rand_span(20), rand_span(20));
            else
                send_point('0, ($urandom_range(1)) ? rand36() : 36'sd0, rand36());
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed points under the reset ellipsoid.
        send_point(36'sd0, 36'sd0, 36'sd0);
        send_point(36'sd0, 36'sd0, 36'sd6356752314);
        send_point(36'sd0, 36'sd0, -36'sd6356752314);
        send_point(-36'sd6378137000, 36'sd0, 36'sd0);
        send_point(36'sd6378137000, 36'sd0, 36'sd0);
        send_point(36'sd0, 36'sd6378137000, 36'sd0);
        send_point(36'sd0, -36'sd6378137000, 36'sd0);
        send_point(-36'sd4000000000, -36'sd3000000000, 36'sd2000000000);
        send_point(-36'sd4000000000, 36'sd3000000000, -36'sd2000000000);
        send_point(36'sd34359738367, 36'sd34359738367, 36'sd34359738367);
        send_point(-36'sd34359738368, -36'sd34359738368, -36'sd34359738368);
        send_point(-36'sd34359738368, 36'sd0, 36'sd34359738367);
        send_point(36'sd1, 36'sd0, 36'sd0);
        send_point(-36'sd1, -36'sd1, 36'sd1);
        send_point(36'sd0, 36'sd1, -36'sd34359738368);
        send_point(36'sd4510731000, 36'sd4510731000, 36'sd1);

        gap_pct = 13;
        random_points(350);

        drain();
        write_reg(c2g_pkg::CFG_SEMI, 37'h1FFFFFFFF);
        write_reg(c2g_pkg::CFG_FLAT, 37'h1FFFFFFFFF);
        write_reg(c2g_pkg::CFG_LIMIT, 37'hFFFF);
        @(negedge clk);
        send_point(36'sd0, 36'sd0, 36'sd0);
        send_point(36'sd8000000000, 36'sd0, 36'sd8000000000);
        random_points(250);

        drain();
        write_reg(c2g_pkg::CFG_SEMI, '0);
        write_reg(c2g_pkg::CFG_FLAT, '0);
        write_reg(c2g_pkg::CFG_LIMIT, '0);
        @(negedge clk);
        gap_pct = 87;
        send_point(36'sd6378137000, 36'sd1000, 36'sd1000);
        random_points(150);

        drain();
        write_reg(c2g_pkg::CFG_SEMI, 37'd6378137000);
        write_reg(c2g_pkg::CFG_FLAT, 37'h1000000000);
        write_reg(c2g_pkg::CFG_LIMIT, 37'd4);
        @(negedge clk);
        random_points(150);

        drain();
        write_reg(c2g_pkg::CFG_SEMI,
                  c2g_pkg::CFG_W'(33'($urandom()) | 33'h100000000));
        write_reg(c2g_pkg::CFG_FLAT, {$urandom(), 5'd0});
        write_reg(c2g_pkg::CFG_LIMIT, c2g_pkg::CFG_W'($urandom_range(1, 200)));
        @(negedge clk);
        gap_pct = 0;
        random_points(300);

        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* cartesian_to_geodetic_core.f */
+incdir+hw/rtl
hw/rtl/c2g_pkg.sv
hw/rtl/c2g_mul.sv
hw/rtl/c2g_cordic.sv
hw/rtl/c2g_datapath.sv
hw/rtl/c2g_ctrl.sv
hw/rtl/cartesian_to_geodetic_core.sv
tb/c2g_checker.sv
tb/cartesian_to_geodetic_core_tb.sv
